/* sv/bf_pkg.sv */
// Package for the burst fragmenter: widths, register indexes, reset values
// and the descriptor and result types used by its modules.
// Depends on nothing.
package bf_pkg;

    localparam int MAX_FRAGS   = 64;
    localparam int SIZE_W      = 20;
    localparam int FRAG_W      = 16;
    localparam int HDR_W       = 8;
    localparam int SEQ_W       = 6;
    localparam int CNT_W       = 7;
    localparam int DIV_STEPS   = SIZE_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] REG_FRAG_SIZE   = 2'd0;
    localparam logic [1:0] REG_HEADER_SIZE = 2'd1;
    localparam logic [1:0] REG_MIN_BURST   = 2'd2;

    localparam logic [FRAG_W-1:0] FRAG_SIZE_RST   = 16'd1200;
    localparam logic [HDR_W-1:0]  HEADER_SIZE_RST = 8'd24;
    localparam logic [SIZE_W-1:0] MIN_BURST_RST   = 20'd3000;

    typedef struct packed {
        logic              bad;
        logic [CNT_W-1:0]  nfull;
        logic              has_pen;
        logic [FRAG_W-1:0] penult;
        logic [FRAG_W-1:0] rem;
        logic [CNT_W-1:0]  total;
        logic [SIZE_W-1:0] payload;
        logic [FRAG_W-1:0] full_bytes;
    } t_desc;

    typedef struct packed {
        logic [31:0]       burst_seq;
        logic [SEQ_W-1:0]  frag_seq;
        logic [CNT_W-1:0]  frag_count;
        logic [SIZE_W-1:0] burst_payload;
        logic [FRAG_W-1:0] frag_bytes;
        logic [31:0]       total_fragments;
        logic [39:0]       total_bytes;
        logic              error;
        logic              last;
    } t_res;

endpackage

/* sv/bf_front.sv */
// Front end of the burst fragmenter: configuration registers, input
// acceptance, a restoring divider and burst classification into a descriptor.
// Depends on bf_pkg.
module bf_front import bf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [SIZE_W-1:0] i_burst_size,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output logic              o_desc_push,
    output t_desc             o_desc,
    input  logic              i_desc_full
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [FRAG_W-1:0] r_f;
    logic [HDR_W-1:0]  r_h;
    logic [SIZE_W-1:0] r_min;
    logic [SIZE_W-1:0] r_size, n_size;
    logic              r_bad0, n_bad0;
    logic [SIZE_W-1:0] r_quo, n_quo;
    logic [FRAG_W-1:0] r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;

    logic [SIZE_W-1:0] raised;
    logic [FRAG_W:0]   trial;
    logic              ge;
    logic [FRAG_W:0]   diff;
    logic              has_pen;
    logic [SIZE_W-1:0] nfull;
    logic              adj;
    logic [FRAG_W:0]   pen_sum;
    logic [FRAG_W-1:0] penult;
    logic [FRAG_W-1:0] rem_v;
    logic [SIZE_W:0]   total;
    logic              bad;
    logic [14:0]       hdr_bytes;

    assign o_cfg_ready = 1'b1;
    assign full        = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f   <= FRAG_SIZE_RST;
            r_h   <= HEADER_SIZE_RST;
            r_min <= MIN_BURST_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAG_SIZE:   r_f   <= i_cfg_data[FRAG_W-1:0];
                REG_HEADER_SIZE: r_h   <= i_cfg_data[HDR_W-1:0];
                REG_MIN_BURST:   r_min <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        raised = (i_burst_size < r_min) ? r_min : i_burst_size;

        trial = {r_rem, r_quo[SIZE_W-1]};
        ge    = (trial >= {1'b0, r_f});
        diff  = trial - {1'b0, r_f};

        has_pen = (r_quo != '0);
        nfull   = r_quo - {{(SIZE_W-1){1'b0}}, has_pen};
        adj     = has_pen && (r_rem != '0) && (r_rem < {{(FRAG_W-HDR_W){1'b0}}, r_h});
        pen_sum = {1'b0, r_f} + {1'b0, r_rem} - {{(FRAG_W+1-HDR_W){1'b0}}, r_h};
        penult  = adj ? pen_sum[FRAG_W-1:0] : r_f;
        rem_v   = adj ? {{(FRAG_W-HDR_W){1'b0}}, r_h} : r_rem;
        total   = {1'b0, nfull} + {{SIZE_W{1'b0}}, has_pen}
                + {{SIZE_W{1'b0}}, (rem_v != '0)};
        bad     = r_bad0
                || (has_pen && (penult < {{(FRAG_W-HDR_W){1'b0}}, r_h}))
                || ((rem_v != '0) && (rem_v < {{(FRAG_W-HDR_W){1'b0}}, r_h}))
                || (total == '0)
                || (total > (SIZE_W+1)'(MAX_FRAGS));
        hdr_bytes = 15'(r_h * total[CNT_W-1:0]);

        o_desc.bad        = bad;
        o_desc.nfull      = nfull[CNT_W-1:0];
        o_desc.has_pen    = has_pen;
        o_desc.penult     = penult;
        o_desc.rem        = rem_v;
        o_desc.total      = total[CNT_W-1:0];
        o_desc.payload    = r_size - {{(SIZE_W-15){1'b0}}, hdr_bytes};
        o_desc.full_bytes = r_f;
    end

    assign o_desc_push = (r_state == S_PUSH) && !i_desc_full;

    always_comb begin
        n_state = r_state;
        n_size  = r_size;
        n_bad0  = r_bad0;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (push) begin
                    n_size  = raised;
                    n_bad0  = (r_f == '0) || (r_f < {{(FRAG_W-HDR_W){1'b0}}, r_h})
                            || (raised < {{(SIZE_W-HDR_W){1'b0}}, r_h});
                    n_quo   = raised;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quo  = {r_quo[SIZE_W-2:0], ge};
                n_rem  = ge ? diff[FRAG_W-1:0] : trial[FRAG_W-1:0];
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_desc_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        r_bad0 <= n_bad0;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
    end

endmodule

/* sv/bf_dq.sv */
// Two-entry descriptor queue between the front and back ends of the
// burst fragmenter.
// Depends on bf_pkg.
module bf_dq import bf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_desc o_desc
);

    t_desc      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_desc  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_desc;
        end
    end

endmodule

/* sv/bf_back.sv */
// Back end of the burst fragmenter: expands a descriptor into fragment
// results, keeps the running counters and holds a two-entry result queue.
// Depends on bf_pkg.
module bf_back import bf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_desc_valid,
    input  t_desc i_desc,
    output logic  o_desc_pop,
    output logic  empty,
    input  logic  pop,
    output t_res  o_res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic              r_state;
    t_desc             r_d;
    logic [CNT_W-1:0]  r_seq;
    logic [31:0]       r_burst;
    logic [31:0]       r_frag;
    logic [39:0]       r_bytes;

    t_res              r_q [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;

    logic              emit;
    logic              do_pop;
    logic [FRAG_W-1:0] bytes_c;
    logic [CNT_W-1:0]  seq_next;
    t_res              res;

    assign o_desc_pop = (r_state == S_IDLE) && i_desc_valid;
    assign emit       = (r_state == S_RUN) && (r_cnt != 2'd2);
    assign empty      = (r_cnt == 2'd0);
    assign do_pop     = pop && !empty;
    assign o_res      = r_q[r_rp];
    assign seq_next   = r_seq + 1'b1;

    always_comb begin
        if (r_seq < r_d.nfull) begin
            bytes_c = r_d.full_bytes;
        end else if (r_d.has_pen && (r_seq == r_d.nfull)) begin
            bytes_c = r_d.penult;
        end else begin
            bytes_c = r_d.rem;
        end

        res.burst_seq = r_burst;
        if (r_d.bad) begin
            res.frag_seq        = '0;
            res.frag_count      = '0;
            res.burst_payload   = '0;
            res.frag_bytes      = '0;
            res.total_fragments = r_frag;
            res.total_bytes     = r_bytes;
            res.error           = 1'b1;
            res.last            = 1'b1;
        end else begin
            res.frag_seq        = r_seq[SEQ_W-1:0];
            res.frag_count      = r_d.total;
            res.burst_payload   = r_d.payload;
            res.frag_bytes      = bytes_c;
            res.total_fragments = r_frag + 32'd1;
            res.total_bytes     = r_bytes + {24'd0, bytes_c};
            res.error           = 1'b0;
            res.last            = (seq_next == r_d.total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seq   <= '0;
            r_burst <= '0;
            r_frag  <= '0;
            r_bytes <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            if (o_desc_pop) begin
                r_state <= S_RUN;
                r_seq   <= '0;
            end else if (emit) begin
                r_seq <= seq_next;
                if (!r_d.bad) begin
                    r_frag  <= res.total_fragments;
                    r_bytes <= res.total_bytes;
                end
                if (res.last) begin
                    r_state <= S_IDLE;
                    if (!r_d.bad) begin
                        r_burst <= r_burst + 32'd1;
                    end
                end
            end
            if (emit) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, emit} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_pop) begin
            r_d <= i_desc;
        end
        if (emit) begin
            r_q[r_wp] <= res;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_seq_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !r_d.bad) |-> (r_seq < r_d.total))
        else $error("fragment index ran past the fragment count");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && res.last) |=> (r_state == S_IDLE))
        else $error("burst did not end after its last fragment");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_d.bad) |-> (res.last && res.frag_count == '0))
        else $error("error result is not a single final result");

endmodule

/* sv/burst_fragmenter.sv */
// Top level of the burst fragmenter: front end, descriptor queue and back end.
// Depends on bf_pkg, bf_front, bf_dq and bf_back.
//
//   Channel  | Handshake                       | Payload
//   ---------+---------------------------------+------------------------------
//   input    | push / full                     | i_burst_size
//   result   | empty / pop                     | o_burst_seq .. o_last
//   config   | i_cfg_valid / o_cfg_ready       | i_cfg_index, i_cfg_data
//
// The front end takes one burst at a time: it accepts it, runs the 20 steps
// of the restoring divider and hands the descriptor to the queue.
// The back end loads a descriptor and then emits one fragment per cycle
// while its result queue has room, so the fragments of a burst overlap
// the division of the next burst.
// Reset restores the default configuration and clears all counters.
// Either side may stall; the queues hold the work until it can move.
module burst_fragmenter import bf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [SIZE_W-1:0] i_burst_size,
    output logic              empty,
    input  logic              pop,
    output logic [31:0]       o_burst_seq,
    output logic [SEQ_W-1:0]  o_frag_seq,
    output logic [CNT_W-1:0]  o_frag_count,
    output logic [SIZE_W-1:0] o_burst_payload,
    output logic [FRAG_W-1:0] o_frag_bytes,
    output logic [31:0]       o_total_fragments,
    output logic [39:0]       o_total_bytes,
    output logic              o_error,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    logic  fd_push, dq_full, dq_empty, dq_pop;
    t_desc fd_desc, dq_desc;
    t_res  res;

    bf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_burst_size (i_burst_size),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_desc_push  (fd_push),
        .o_desc       (fd_desc),
        .i_desc_full  (dq_full)
    );

    bf_dq u_dq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fd_push),
        .i_desc  (fd_desc),
        .o_full  (dq_full),
        .i_pop   (dq_pop),
        .o_empty (dq_empty),
        .o_desc  (dq_desc)
    );

    bf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (!dq_empty),
        .i_desc       (dq_desc),
        .o_desc_pop   (dq_pop),
        .empty        (empty),
        .pop          (pop),
        .o_res        (res)
    );

    assign o_burst_seq       = res.burst_seq;
    assign o_frag_seq        = res.frag_seq;
    assign o_frag_count      = res.frag_count;
    assign o_burst_payload   = res.burst_payload;
    assign o_frag_bytes      = res.frag_bytes;
    assign o_total_fragments = res.total_fragments;
    assign o_total_bytes     = res.total_bytes;
    assign o_error           = res.error;
    assign o_last            = res.last;

endmodule
